// ----- design/msct_pkg.sv -----
// Shared types and constants for the multi-slot countdown timer.
// Used by the top level of the block, its checkers and its testbench; depends on nothing.
package msct_pkg;

   localparam int SLOTS_DEF       = 16;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int EXP_CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_CANCEL  = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_TICK    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_INVALID     = 3'd1,
      STAT_NO_SPACE    = 3'd2,
      STAT_CANCELLED   = 3'd3,
      STAT_ALREADY_EXP = 3'd4,
      STAT_RUNNING     = 3'd5,
      STAT_EXPIRED     = 3'd6,
      STAT_NONE        = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      MODE_RUN    = 2'd0,
      MODE_DONE   = 2'd1,
      MODE_CANCEL = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef struct packed {
      func_type    func;
      logic [15:0] seconds;
      logic [3:0]  slot;
      logic [31:0] tag;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot_id;
      logic [31:0] tag_out;
      logic        last;
   } rsp_type;

endpackage

// ----- design/msct_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; depends on nothing.
module msct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/multi_slot_countdown_timer.sv -----
// Top level of the multi-slot countdown timer: sequencer around the slot table.
// Depends on msct_pkg and msct_ram.
//
// Usage:
//   A command beat (add, cancel, release or tick) is taken at a rising edge
//   where start is high and busy is low. Results leave on rsp_item, each
//   valid for one cycle while rsp_strobe is high; rsp_item.last marks the
//   final result of a command. The receiver cannot hold results off.
//   All slot state sits in one RAM with a registered read, so every
//   command is a read-modify-write walk over table entries:
//     cancel, release: one entry is read, then evaluated; a bad slot id
//                     is answered at once without a lookup.
//     add:            a walk from slot 0 up to the lowest free slot, or
//                     over the whole table when it is full.
//     tick:           a walk over every slot; each expiry result goes
//                     out as the walk finds the next, the last after the walk.
//   busy stays high until the final result of a command has been issued, so
//   one command is in flight at a time on the single RAM read port.
//   After reset the block clears the in-use bit of every slot, one slot per
//   cycle, holding busy high until the last slot is cleared.
module multi_slot_countdown_timer
   import msct_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef struct packed {
      logic                   used;
      mode_type               mode;
      logic [COUNT_WIDTH-1:0] count;
      logic [31:0]            tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_TAIL
   } state_type;

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     rd_live_ff, rd_live_in;
   logic                     ev_live_ff, ev_live_in;
   logic [IDX_W-1:0]         ev_idx_ff, ev_idx_in;
   logic                     ev_last_ff, ev_last_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic [31:0]              pend_tag_ff, pend_tag_in;
   logic [EXP_CNT_W-1:0]     exp_cnt_ff, exp_cnt_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   entry_type                wr_entry;
   entry_type                rd_entry;
   logic [ENTRY_W-1:0]       rd_bits;
   logic                     rd_last;
   logic                     single_op;
   logic                     bad_slot;
   logic [31:0]              secs32;
   logic [COUNT_WIDTH-1:0]   add_count;

   msct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_bits)
   );

   assign rd_entry  = entry_type'(rd_bits);
   assign single_op = (req_ff.func == FUNC_CANCEL) || (req_ff.func == FUNC_RELEASE);
   assign rd_last   = single_op || (rd_idx_ff == LAST_IDX);
   assign bad_slot  = (32'(req_item.slot) >= 32'(SLOTS));
   assign secs32    = 32'(req_ff.seconds);
   assign add_count = (secs32 > CNT_MAX32) ? COUNT_WIDTH'(CNT_MAX32)
                                           : COUNT_WIDTH'(secs32);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      rd_live_in    = rd_live_ff;
      ev_live_in    = 1'b0;
      ev_idx_in     = rd_idx_ff;
      ev_last_in    = rd_last;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      pend_tag_in   = pend_tag_ff;
      exp_cnt_in    = exp_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{status: STAT_OK, slot_id: 4'd0, tag_out: 32'd0, last: 1'b1};
      wr_en         = 1'b0;
      wr_addr       = ev_idx_ff;
      wr_entry      = rd_entry;

      case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = rd_idx_ff;
            wr_entry = '0;
            if (rd_idx_ff == LAST_IDX) begin
               state_in  = S_IDLE;
               rd_idx_in = '0;
            end else begin
               rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in     = req_item;
               pend_in    = 1'b0;
               exp_cnt_in = '0;
               if ((req_item.func == FUNC_CANCEL || req_item.func == FUNC_RELEASE)
                   && bad_slot) begin
                  // An id past the table answers at once without a lookup.
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = STAT_INVALID;
               end else begin
                  state_in   = S_WALK;
                  rd_live_in = 1'b1;
                  if (req_item.func == FUNC_ADD || req_item.func == FUNC_TICK) begin
                     rd_idx_in = '0;
                  end else begin
                     rd_idx_in = IDX_W'(req_item.slot);
                  end
               end
            end
         end

         S_WALK: begin
            // Read stage: one entry address per cycle.
            if (rd_live_ff) begin
               ev_live_in = 1'b1;
               ev_idx_in  = rd_idx_ff;
               ev_last_in = rd_last;
               rd_live_in = !rd_last;
               if (!rd_last) begin
                  rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
               end
            end
            // Evaluate stage: entry read in the previous cycle.
            if (ev_live_ff) begin
               case (req_ff.func)
                  FUNC_ADD: begin
                     if (!rd_entry.used) begin
                        wr_en          = 1'b1;
                        wr_entry.used  = 1'b1;
                        wr_entry.mode  = MODE_RUN;
                        wr_entry.count = add_count;
                        wr_entry.tag   = req_ff.tag;
                        rsp_strobe_in  = 1'b1;
                        rsp_in.slot_id = 4'(ev_idx_ff);
                        state_in       = S_IDLE;
                        rd_live_in     = 1'b0;
                        ev_live_in     = 1'b0;
                     end else if (ev_last_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_NO_SPACE;
                        state_in      = S_IDLE;
                     end
                  end
                  FUNC_CANCEL: begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                     if (!rd_entry.used) begin
                        rsp_in.status = STAT_INVALID;
                     end else if (rd_entry.mode == MODE_CANCEL) begin
                        rsp_in.status = STAT_CANCELLED;
                     end else if (rd_entry.mode == MODE_DONE) begin
                        rsp_in.status = STAT_ALREADY_EXP;
                     end else begin
                        wr_en         = 1'b1;
                        wr_entry.mode = MODE_CANCEL;
                     end
                  end
                  FUNC_RELEASE: begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                     if (!rd_entry.used) begin
                        rsp_in.status = STAT_INVALID;
                     end else if (rd_entry.mode == MODE_RUN) begin
                        rsp_in.status = STAT_RUNNING;
                     end else begin
                        wr_en         = 1'b1;
                        wr_entry.used = 1'b0;
                     end
                  end
                  default: begin
                     if (rd_entry.used && rd_entry.mode == MODE_RUN) begin
                        wr_en = 1'b1;
                        if (rd_entry.count <= COUNT_WIDTH'(1)) begin
                           wr_entry.count = '0;
                           wr_entry.mode  = MODE_DONE;
                           // Hold each expiry back one find, so the final one
                           // can carry last after the walk.
                           if (32'(exp_cnt_ff) < 32'(MAX_RESULTS)) begin
                              if (pend_ff) begin
                                 rsp_strobe_in  = 1'b1;
                                 rsp_in.status  = STAT_EXPIRED;
                                 rsp_in.slot_id = 4'(pend_idx_ff);
                                 rsp_in.tag_out = pend_tag_ff;
                                 rsp_in.last    = 1'b0;
                              end
                              pend_in     = 1'b1;
                              pend_idx_in = ev_idx_ff;
                              pend_tag_in = rd_entry.tag;
                              exp_cnt_in  = EXP_CNT_W'(exp_cnt_ff + 1'b1);
                           end
                        end else begin
                           wr_entry.count = COUNT_WIDTH'(rd_entry.count - 1'b1);
                        end
                     end
                     if (ev_last_ff) begin
                        state_in = S_TAIL;
                     end
                  end
               endcase
            end
         end

         S_TAIL: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (pend_ff) begin
               rsp_in.status  = STAT_EXPIRED;
               rsp_in.slot_id = 4'(pend_idx_ff);
               rsp_in.tag_out = pend_tag_ff;
            end else begin
               rsp_in.status = STAT_NONE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rd_idx_ff     <= '0;
         rd_live_ff    <= 1'b0;
         ev_live_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         exp_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         rd_live_ff    <= rd_live_in;
         ev_live_ff    <= ev_live_in;
         pend_ff       <= pend_in;
         exp_cnt_ff    <= exp_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      ev_idx_ff   <= ev_idx_in;
      ev_last_ff  <= ev_last_in;
      pend_idx_ff <= pend_idx_in;
      pend_tag_ff <= pend_tag_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- design/msct_checker.sv -----
// Port-level checker for the multi-slot countdown timer, bound to the top level.
// Depends on msct_pkg.
module msct_checker
   import msct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Only tick expiries can be followed by more results of the same command.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != STAT_EXPIRED |-> rsp_item.last)
      else $error("non-expiry result without last");

   // The final beat of a command leaves the block ready for the next one.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |-> !busy)
      else $error("busy still high on final result");

   // More results are owed after a beat without last.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("not busy while results are outstanding");

   // In the next cycle either the walk goes on or the final beat is out.
   a_more_next: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=> busy || rsp_strobe)
      else $error("command finished before its last result");

   a_no_space_id: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == STAT_NO_SPACE |-> rsp_item.slot_id == 4'd0)
      else $error("slot id on a full-table result");

endmodule

bind multi_slot_countdown_timer msct_checker u_msct_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);

// ----- sim/msct_checker.sv -----
// Checker for the multi-slot countdown timer: watches the command and result channels,
// predicts every result beat from its own copy of the slot table and compares them.
// Depends on msct_pkg for the beat types, the function and status codes and the slot modes.
`timescale 1ns / 100ps

module msct_tb_checker
   import msct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_count,
   output int      result_count
);

   localparam int COUNT_LIMIT = (1 << COUNT_WIDTH_DEF) - 1;

   // Shadow copy of the slot table.
   logic                       in_use     [SLOTS_DEF];
   mode_type                   slot_state [SLOTS_DEF];
   logic [COUNT_WIDTH_DEF-1:0] count_left [SLOTS_DEF];
   logic [31:0]                slot_tag   [SLOTS_DEF];

   rsp_type awaited_results [$];
   rsp_type oldest;
   int      mismatches;
   int      results_seen;

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 50) begin
         $display("[%0t] checker: %s", $time, msg);
      end
   endtask

   // Applies one accepted command to the shadow table and queues the result beats it causes.
   task automatic apply_timer_command(input req_type cmd);
      rsp_type beat;
      rsp_type held;
      bit      found;
      bit      have_held;
      int      expiries;
      beat = '0;
      beat.last = 1'b1;
      case (cmd.func)
         FUNC_ADD: begin
            found = 1'b0;
            beat.status = STAT_NO_SPACE;
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (!found && !in_use[i]) begin
                  found = 1'b1;
                  in_use[i] = 1'b1;
                  slot_state[i] = MODE_RUN;
                  count_left[i] = (int'(cmd.seconds) > COUNT_LIMIT) ? COUNT_LIMIT[COUNT_WIDTH_DEF-1:0]
                                                                    : cmd.seconds;
                  slot_tag[i] = cmd.tag;
                  beat.status = STAT_OK;
                  beat.slot_id = 4'(i);
               end
            end
            awaited_results.push_back(beat);
         end
         FUNC_CANCEL, FUNC_RELEASE: begin
            if (int'(cmd.slot) >= SLOTS_DEF || !in_use[cmd.slot]) begin
               beat.status = STAT_INVALID;
            end else if (cmd.func == FUNC_CANCEL) begin
               if (slot_state[cmd.slot] == MODE_CANCEL) begin
                  beat.status = STAT_CANCELLED;
               end else if (slot_state[cmd.slot] == MODE_DONE) begin
                  beat.status = STAT_ALREADY_EXP;
               end else begin
                  slot_state[cmd.slot] = MODE_CANCEL;
                  beat.status = STAT_OK;
               end
            end else begin
               if (slot_state[cmd.slot] == MODE_RUN) begin
                  beat.status = STAT_RUNNING;
               end else begin
                  in_use[cmd.slot] = 1'b0;
                  beat.status = STAT_OK;
               end
            end
            awaited_results.push_back(beat);
         end
         default: begin
            // A tick: the latest expiry is held back so that last can be set on it.
            expiries = 0;
            have_held = 1'b0;
            held = '0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (in_use[i] && slot_state[i] == MODE_RUN) begin
                  if (count_left[i] <= 1) begin
                     count_left[i] = '0;
                     slot_state[i] = MODE_DONE;
                     if (expiries < MAX_RESULTS) begin
                        if (have_held) begin
                           awaited_results.push_back(held);
                        end
                        held = '0;
                        held.status = STAT_EXPIRED;
                        held.slot_id = 4'(i);
                        held.tag_out = slot_tag[i];
                        have_held = 1'b1;
                        expiries++;
                     end
                  end else begin
                     count_left[i] = count_left[i] - 1'b1;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               awaited_results.push_back(held);
            end else begin
               beat.status = STAT_NONE;
               awaited_results.push_back(beat);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS_DEF; i++) begin
            in_use[i] = 1'b0;
            slot_state[i] = MODE_RUN;
            count_left[i] = '0;
            slot_tag[i] = '0;
         end
         awaited_results.delete();
      end else begin
         // A result beat that ends in this cycle is compared before a command taken at the
         // same edge adds its own expectations behind it.
         if (rsp_strobe === 1'b1) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               flag_mismatch($sformatf("result beat with nothing awaited: status %0d slot %0d",
                                       rsp_item.status, rsp_item.slot_id));
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_item.status !== oldest.status) begin
                  flag_mismatch($sformatf("status is %0d, should be %0d",
                                          rsp_item.status, oldest.status));
               end
               if (rsp_item.slot_id !== oldest.slot_id) begin
                  flag_mismatch($sformatf("slot_id is %0d, should be %0d",
                                          rsp_item.slot_id, oldest.slot_id));
               end
               if (rsp_item.tag_out !== oldest.tag_out) begin
                  flag_mismatch($sformatf("tag_out is %h, should be %h",
                                          rsp_item.tag_out, oldest.tag_out));
               end
               if (rsp_item.last !== oldest.last) begin
                  flag_mismatch($sformatf("last is %b, should be %b",
                                          rsp_item.last, oldest.last));
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            flag_mismatch("result strobe is unknown");
         end
         if (start === 1'b1 && busy === 1'b0) begin
            apply_timer_command(req_item);
         end
      end
      fail_count    <= mismatches;
      pending_count <= awaited_results.size();
      result_count  <= results_seen;
   end

endmodule

// ----- sim/multi_slot_countdown_timer_test.sv -----
// Top of the countdown timer testbench: clock, reset, directed and random command beats.
// Depends on msct_pkg, the multi_slot_countdown_timer block and the msct_tb_checker module.
`timescale 1ns / 100ps

module multi_slot_countdown_timer_test;
   import msct_pkg::*;

   localparam int RANDOM_BEATS = 100;
   localparam int MAX_GAP      = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_item;
   rsp_type rsp_item;

   int fail_count;
   int pending_count;
   int result_count;
   int idle_pct;
   int beats_sent;

   multi_slot_countdown_timer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   msct_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(200_000 * 12);
      $display("Timeout: %0d result beats still awaited", pending_count);
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type make_cmd(input func_type f, input logic [15:0] secs,
                                        input logic [3:0] id, input logic [31:0] tagv);
      req_type cmd;
      cmd.func = f;
      cmd.seconds = secs;
      cmd.slot = id;
      cmd.tag = tagv;
      return cmd;
   endfunction

   function automatic req_type noise_cmd();
      return make_cmd(func_type'($urandom_range(3)), 16'($urandom), 4'($urandom), $urandom);
   endfunction

   // Mostly short counts so that slots keep expiring, now and then a long one.
   function automatic logic [15:0] pick_seconds();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return 16'($urandom_range(4));
      end else if (roll < 85) begin
         return 16'($urandom_range(40));
      end
      return 16'($urandom_range(65535));
   endfunction

   // Drives one command beat after a random idle gap and holds it until it is taken.
   task automatic send_command(input req_type cmd);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_item <= noise_cmd();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
   endtask

   initial begin
      int random_start;
      int phase;
      int pick;
      logic [3:0] id;

      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      idle_pct = 0;
      beats_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, bad ids, a full table, extreme counts and tags, every status.
      send_command(make_cmd(FUNC_TICK, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
      send_command(make_cmd(FUNC_CANCEL, 16'h0000, 4'hF, 32'h0000_0000));
      send_command(make_cmd(FUNC_RELEASE, 16'h0000, 4'h0, 32'h0000_0000));
      send_command(make_cmd(FUNC_ADD, 16'h0000, 4'hF, 32'hFFFF_FFFF));
      send_command(make_cmd(FUNC_ADD, 16'h0001, 4'h0, 32'h0000_0000));
      send_command(make_cmd(FUNC_ADD, 16'hFFFF, 4'hA, 32'hA5A5_5A5A));
      send_command(make_cmd(FUNC_ADD, 16'h0002, 4'h5, 32'h1234_5678));
      for (int k = 4; k < SLOTS_DEF; k++) begin
         send_command(make_cmd(FUNC_ADD, 16'($urandom_range(3, 20)), 4'($urandom), $urandom));
      end
      send_command(make_cmd(FUNC_ADD, 16'h0005, 4'h0, 32'hDEAD_BEEF));
      send_command(make_cmd(FUNC_RELEASE, 16'h0000, 4'h2, 32'h0000_0000));
      send_command(make_cmd(FUNC_CANCEL, 16'h0000, 4'h2, 32'h0000_0000));
      send_command(make_cmd(FUNC_CANCEL, 16'h0000, 4'h2, 32'h0000_0000));
      send_command(make_cmd(FUNC_TICK, 16'h0000, 4'h0, 32'h0000_0000));
      send_command(make_cmd(FUNC_CANCEL, 16'h0000, 4'h0, 32'h0000_0000));
      send_command(make_cmd(FUNC_RELEASE, 16'h0000, 4'h0, 32'h0000_0000));
      send_command(make_cmd(FUNC_RELEASE, 16'h0000, 4'h2, 32'h0000_0000));
      send_command(make_cmd(FUNC_ADD, 16'h0003, 4'h9, 32'h0F0F_F0F0));
      send_command(make_cmd(FUNC_TICK, 16'h0000, 4'h0, 32'h0000_0000));

      // Random: four idle phases in turn, mostly well-formed add, tick, cancel and release
      // sequences, with a share of noise beats.
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         phase = (beats_sent - random_start) * 4 / RANDOM_BEATS;
         case (phase)
            1:       idle_pct = 73;
            3:       idle_pct = 34;
            default: idle_pct = 0;
         endcase
         pick = $urandom_range(10);
         id = 4'($urandom);
         case (pick)
            0, 1, 2: begin
               send_command(make_cmd(FUNC_ADD, pick_seconds(), 4'($urandom), $urandom));
            end
            3, 4: begin
               send_command(make_cmd(FUNC_TICK, 16'($urandom), 4'($urandom), $urandom));
            end
            5: begin
               repeat ($urandom_range(2, 5)) begin
                  send_command(make_cmd(FUNC_TICK, 16'($urandom), 4'($urandom), $urandom));
               end
            end
            6, 7: begin
               send_command(make_cmd(FUNC_CANCEL, 16'($urandom), id, $urandom));
               send_command(make_cmd(FUNC_RELEASE, 16'($urandom), id, $urandom));
            end
            8: begin
               send_command(make_cmd(FUNC_RELEASE, 16'($urandom), id, $urandom));
            end
            9: begin
               send_command(noise_cmd());
            end
            default: begin
               // Fill the table with short counts so that one tick expires many slots at once,
               // then release every slot.
               repeat (SLOTS_DEF + 1) begin
                  send_command(make_cmd(FUNC_ADD, 16'($urandom_range(2)), 4'($urandom),
                                        $urandom));
               end
               send_command(make_cmd(FUNC_TICK, 16'($urandom), 4'($urandom), $urandom));
               send_command(make_cmd(FUNC_TICK, 16'($urandom), 4'($urandom), $urandom));
               for (int k = 0; k < SLOTS_DEF; k++) begin
                  send_command(make_cmd(FUNC_RELEASE, 16'($urandom), 4'(k), $urandom));
               end
            end
         endcase
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4 * SLOTS_DEF) @(posedge clock);

      $display("Covered %0d command beats (directed, then random over four idle phases)",
               beats_sent);
      $display("and %0d result beats, including full-table adds and multi-slot expiries.",
               result_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/msct_pkg.sv
design/msct_ram.sv
design/multi_slot_countdown_timer.sv
design/msct_checker.sv
sim/msct_checker.sv
sim/multi_slot_countdown_timer_test.sv
